// ===== rtl/scbd_pkg.sv =====
// ----------------------------------------------------------------------------
// scbd_pkg
// Shared types and constants for the sound-CPU bus decoder.
// ----------------------------------------------------------------------------
package scbd_pkg;

    typedef enum logic [3:0] {
        TGT_LOCAL  = 4'd0,
        TGT_FM     = 4'd1,
        TGT_VDATA  = 4'd2,
        TGT_VCTRL  = 4'd3,
        TGT_VCOUNT = 4'd4,
        TGT_HCOUNT = 4'd5,
        TGT_TONE   = 4'd6,
        TGT_VTEST  = 4'd7,
        TGT_MAIN   = 4'd8
    } t_target;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // video port codes after masking the low address byte
    localparam logic [7:0] VP_DATA_HI = 8'h00;
    localparam logic [7:0] VP_DATA_LO = 8'h01;
    localparam logic [7:0] VP_CTRL_HI = 8'h04;
    localparam logic [7:0] VP_CTRL_LO = 8'h05;
    localparam logic [7:0] VP_VCNT_A  = 8'h08;
    localparam logic [7:0] VP_VCNT_B  = 8'h0C;
    localparam logic [7:0] VP_HCNT_A  = 8'h09;
    localparam logic [7:0] VP_HCNT_B  = 8'h0D;
    localparam logic [7:0] VP_TONE_A  = 8'h10;
    localparam logic [7:0] VP_TONE_B  = 8'h14;
    localparam logic [7:0] VP_TEST    = 8'h1C;
    localparam logic [7:0] VP_RD_MASK = 8'hFD;
    localparam logic [7:0] VP_WR_MASK = 8'hFC;

    localparam logic [7:0] PORT_PAGE  = 8'h7F;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [2:0] HIGH_BANK  = 3'b111;
    localparam int         BANK_W     = 9;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        sound_reset;
    } t_req;

    typedef struct packed {
        t_target     target;
        logic [7:0]  fixed_rd;
        logic        use_ram;
        logic        high_byte;
        logic [23:0] device_address;
        logic [7:0]  device_data;
        logic        device_write;
        logic        ram_we;
        logic        bank_we;
    } t_dec;

endpackage

// ===== rtl/scbd_if.sv =====
// ----------------------------------------------------------------------------
// scbd_if
// Valid/ready channels for bus requests and decode results.
// ----------------------------------------------------------------------------
interface scbd_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        sound_reset;

    modport source (output valid, operation, address, write_data, sound_reset,
                    input ready);
    modport sink   (input valid, operation, address, write_data, sound_reset,
                    output ready);
endinterface

interface scbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  target;
    logic [7:0]  read_data;
    logic        high_byte;
    logic [23:0] device_address;
    logic [7:0]  device_data;
    logic        device_write;

    modport source (output valid, target, read_data, high_byte, device_address,
                    device_data, device_write, input ready);
    modport sink   (input valid, target, read_data, high_byte, device_address,
                    device_data, device_write, output ready);
endinterface

// ===== rtl/sound_cpu_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// sound_cpu_bus_decoder
// Sound-CPU bus decoder: local RAM, bank register and main-bus window.
//
//   channel  dir  handshake      contents
//   i_req    in   valid/ready    operation, address, write_data, sound_reset
//   o_rsp    out  valid/ready    target, read_data, high_byte, device fields
//
// one transfer accepted per cycle while o_rsp is not stalled; each request
// passes the input register, then the result register (which offers it,
// with read data from the RAM read); after reset the local RAM is cleared
// one entry a cycle, all RAM_DEPTH entries, with i_req.ready low
// a stall on o_rsp holds the result register and backs up into i_req.ready
// ----------------------------------------------------------------------------
module sound_cpu_bus_decoder
    import scbd_pkg::*;
#(
    parameter int RAM_DEPTH = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scbd_req_if.sink   i_req,
    scbd_rsp_if.source o_rsp
);

    localparam int AW = $clog2(RAM_DEPTH);

    logic              r_s1_valid;
    t_req              r_s1;
    logic              r_s2_valid;
    t_dec              r_s2;
    logic [BANK_W-1:0] r_bank;
    logic              r_clearing;
    logic [AW-1:0]     r_clr_cnt;

    t_dec              w_dec;
    logic [AW-1:0]     w_ram_idx;
    logic              w_s1_adv;
    logic              w_in_ready;
    logic              w_ram_en;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_addr;
    logic [7:0]        w_ram_wdata;
    logic [7:0]        w_ram_rdata;

    assign w_s1_adv   = r_s1_valid && (!r_s2_valid || o_rsp.ready);
    assign w_in_ready = !r_clearing && (!r_s1_valid || w_s1_adv);
    assign i_req.ready = w_in_ready;

    scbd_decode #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_decode (
        .i_req     (r_s1),
        .i_bank    (r_bank),
        .o_dec     (w_dec),
        .o_ram_idx (w_ram_idx)
    );

    always_comb begin
        if (r_clearing) begin
            w_ram_en    = 1'b1;
            w_ram_we    = 1'b1;
            w_ram_addr  = r_clr_cnt;
            w_ram_wdata = '0;
        end else begin
            w_ram_en    = w_s1_adv && (w_dec.use_ram || w_dec.ram_we);
            w_ram_we    = w_dec.ram_we;
            w_ram_addr  = w_ram_idx;
            w_ram_wdata = r_s1.write_data;
        end
    end

    scbd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_bank     <= '0;
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(RAM_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_in_ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s1_adv && w_dec.bank_we) begin
                r_bank <= {r_s1.write_data[0], r_bank[BANK_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_s1.operation   <= i_req.operation;
            r_s1.address     <= i_req.address;
            r_s1.write_data  <= i_req.write_data;
            r_s1.sound_reset <= i_req.sound_reset;
        end
        if (w_s1_adv) begin
            r_s2 <= w_dec;
        end
    end

    assign o_rsp.valid          = r_s2_valid;
    assign o_rsp.target         = r_s2.target;
    assign o_rsp.read_data      = r_s2.use_ram ? w_ram_rdata : r_s2.fixed_rd;
    assign o_rsp.high_byte      = r_s2.high_byte;
    assign o_rsp.device_address = r_s2.device_address;
    assign o_rsp.device_data    = r_s2.device_data;
    assign o_rsp.device_write   = r_s2.device_write;

endmodule

// ===== rtl/scbd_ram.sv =====
// ----------------------------------------------------------------------------
// scbd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scbd_decode.sv =====
// ----------------------------------------------------------------------------
// scbd_decode
// Address decode of one bus access, main-bus window and RAM mirroring.
// ----------------------------------------------------------------------------
module scbd_decode
    import scbd_pkg::*;
#(
    parameter int RAM_DEPTH = 8192
) (
    input  t_req                         i_req,
    input  logic [BANK_W-1:0]            i_bank,
    output t_dec                         o_dec,
    output logic [$clog2(RAM_DEPTH)-1:0] o_ram_idx
);

    localparam int AW = $clog2(RAM_DEPTH);

    logic [3:0]  w_page;
    logic [7:0]  w_rsel;
    logic [7:0]  w_wsel;
    logic        w_ports;
    logic [23:0] w_main;
    logic [17:0] w_rem;

    assign w_page  = i_req.address[15:12];
    assign w_rsel  = i_req.address[7:0] & VP_RD_MASK;
    assign w_wsel  = i_req.address[7:0] & VP_WR_MASK;
    assign w_ports = (i_req.address[15:8] == PORT_PAGE);
    assign w_main  = {i_bank, i_req.address[14:0]};

    // mirror index: (address & 0x3fff) mod depth, quotient at most 15
    always_comb begin
        w_rem = {4'd0, i_req.address[13:0]};
        for (int k = 3; k >= 0; k--) begin
            if (w_rem >= 18'(RAM_DEPTH << k)) begin
                w_rem = w_rem - 18'(RAM_DEPTH << k);
            end
        end
    end

    assign o_ram_idx = w_rem[AW-1:0];

    always_comb begin
        o_dec = '0;
        o_dec.target = TGT_LOCAL;
        if (i_req.operation == OP_READ) begin
            case (w_page)
                4'h0, 4'h1, 4'h2, 4'h3: begin
                    o_dec.use_ram = 1'b1;
                end
                4'h4, 4'h5: begin
                    if (i_req.sound_reset) begin
                        o_dec.fixed_rd = FILL_BYTE;
                    end else begin
                        o_dec.target         = TGT_FM;
                        o_dec.device_address = {22'd0, i_req.address[1:0]};
                    end
                end
                4'h6: begin
                    o_dec.fixed_rd = FILL_BYTE;
                end
                4'h7: begin
                    if (w_ports) begin
                        case (w_rsel)
                            VP_DATA_HI: begin
                                o_dec.target    = TGT_VDATA;
                                o_dec.high_byte = 1'b1;
                            end
                            VP_DATA_LO: o_dec.target = TGT_VDATA;
                            VP_CTRL_HI: begin
                                o_dec.target    = TGT_VCTRL;
                                o_dec.high_byte = 1'b1;
                            end
                            VP_CTRL_LO: o_dec.target = TGT_VCTRL;
                            VP_VCNT_A, VP_VCNT_B: o_dec.target = TGT_VCOUNT;
                            VP_HCNT_A, VP_HCNT_B: o_dec.target = TGT_HCOUNT;
                            default: ;
                        endcase
                    end
                end
                default: begin
                    if (i_bank[BANK_W-1 -: 3] == HIGH_BANK) begin
                        o_dec.fixed_rd = FILL_BYTE;
                    end else begin
                        o_dec.target         = TGT_MAIN;
                        o_dec.device_address = w_main;
                    end
                end
            endcase
        end else begin
            case (w_page)
                4'h0, 4'h1, 4'h2, 4'h3: begin
                    o_dec.ram_we = 1'b1;
                end
                4'h4, 4'h5: begin
                    if (!i_req.sound_reset) begin
                        o_dec.target         = TGT_FM;
                        o_dec.device_address = {22'd0, i_req.address[1:0]};
                        o_dec.device_write   = 1'b1;
                    end
                end
                4'h6: begin
                    o_dec.bank_we = (i_req.address[11:8] == 4'h0);
                end
                4'h7: begin
                    if (w_ports) begin
                        case (w_wsel)
                            VP_DATA_HI: begin
                                o_dec.target       = TGT_VDATA;
                                o_dec.device_write = 1'b1;
                            end
                            VP_CTRL_HI: begin
                                o_dec.target       = TGT_VCTRL;
                                o_dec.device_write = 1'b1;
                            end
                            VP_TONE_A, VP_TONE_B: begin
                                if (i_req.address[0]) begin
                                    o_dec.target       = TGT_TONE;
                                    o_dec.device_write = 1'b1;
                                end
                            end
                            VP_TEST: begin
                                o_dec.target       = TGT_VTEST;
                                o_dec.device_write = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                default: begin
                    o_dec.target         = TGT_MAIN;
                    o_dec.device_address = w_main;
                    o_dec.device_write   = 1'b1;
                end
            endcase
            if (o_dec.device_write) begin
                o_dec.device_data = i_req.write_data;
            end
        end
    end

endmodule

// ===== rtl/scbd_checker.sv =====
// ----------------------------------------------------------------------------
// scbd_checker
// Port-level assertions for the sound-CPU bus decoder.
// ----------------------------------------------------------------------------
module scbd_checker
    import scbd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [3:0]  i_target,
    input logic [7:0]  i_read_data,
    input logic        i_high_byte,
    input logic [23:0] i_device_address,
    input logic [7:0]  i_device_data,
    input logic        i_device_write
);

    // stalled result stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result withdrawn while stalled");

    // stalled result keeps target, read data, device address and device data
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_target) && $stable(i_read_data)
            && $stable(i_device_address) && $stable(i_device_data))
        else $error("result payload changed while stalled");

    // a forwarded write always names a device, never the local target
    a_write_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_device_write |-> i_target != TGT_LOCAL && i_read_data == 8'd0)
        else $error("forwarded write without device target");

    // high byte flag only on video data/control reads
    a_high_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_high_byte |->
            (i_target == TGT_VDATA || i_target == TGT_VCTRL) && !i_device_write)
        else $error("high byte flag on wrong target");

    // device data only travels with a write
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_device_write |-> i_device_data == 8'd0)
        else $error("device data without write");

endmodule

bind sound_cpu_bus_decoder scbd_checker u_scbd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_target         (o_rsp.target),
    .i_read_data      (o_rsp.read_data),
    .i_high_byte      (o_rsp.high_byte),
    .i_device_address (o_rsp.device_address),
    .i_device_data    (o_rsp.device_data),
    .i_device_write   (o_rsp.device_write)
);
